FILE: rtl/core/arls_pkg.sv
// ----------------------------------------------------------------------------
// arls_pkg: shared definitions for the addressable RGB LED serializer
// Item kinds, register indexes, bit counts and the color reorder helper.
// ----------------------------------------------------------------------------
`default_nettype none

package arls_pkg;

  // Kind of an input transaction, carried in tuser.
  typedef enum logic [1:0] {
    FUNC_SET_ONE = 2'd0,
    FUNC_SET_ALL = 2'd1,
    FUNC_START   = 2'd2,
    FUNC_TICK    = 2'd3
  } func_t;

  // Configuration register indexes.
  localparam logic [1:0] CFG_ZERO_HIGH = 2'd0;
  localparam logic [1:0] CFG_ZERO_LOW  = 2'd1;
  localparam logic [1:0] CFG_ONE_HIGH  = 2'd2;
  localparam logic [1:0] CFG_ONE_LOW   = 2'd3;

  // Register reset values.
  localparam logic [7:0] ZERO_HIGH_RST = 8'd1;
  localparam logic [7:0] ZERO_LOW_RST  = 8'd8;
  localparam logic [7:0] ONE_HIGH_RST  = 8'd8;
  localparam logic [7:0] ONE_LOW_RST   = 8'd1;

  localparam int         COLOR_W        = 24;
  localparam int         INDEX_W        = 16;
  localparam logic [4:0] BITS_PER_PIXEL = 5'd24;

  typedef logic [COLOR_W-1:0] color_t;

  // Stored colors are 0xRRGGBB; the wire wants green, red, then blue.
  function automatic color_t grb_word(input color_t rgb);
    return {rgb[15:8], rgb[23:16], rgb[7:0]};
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/arls_ram.sv
// ----------------------------------------------------------------------------
// arls_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module arls_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 64
) (
  input  wire logic                                      clk,
  input  wire logic                                      we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                          wdata,
  input  wire logic                                      re,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/addressable_rgb_led_serializer.sv
// ----------------------------------------------------------------------------
// addressable_rgb_led_serializer: single-wire GRB LED frame serializer
// Pixel store plus pulse-width serializer advanced by tick transactions.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream: tuser selects set one pixel, set all pixels, start frame or
//   tick; tdata carries pixel index and color. Every input transaction gives
//   exactly one output transaction: tdata[0] is the line level, tuser[0] is
//   busy and tlast marks the tick that ends the frame.
//   Transactions pass the input register and then the output register; one
//   is taken every cycle while the output is not stalled. The pixel index
//   reduction is split across the input register and the processing stage,
//   and the next pixel is fetched from the store RAM in the cycle after a
//   pixel ends, so ticks can stream back to back and pulse widths are exact in ticks.
//   Set all pixels takes effect at once through a fill color register and
//   per-pixel written flags; no clearing pass is needed after reset.
//   Reset clears the store to black, stops any frame and loads the default
//   tick counts. A stalled output register holds its transaction; one more
//   input transaction is buffered in the input register before in_tready
//   drops.
//   Configuration writes take effect on the next cycle and must be made
//   while the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module addressable_rgb_led_serializer #(
  parameter int LED_COUNT = 64
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // Configuration write port
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [7:0]  cfg_wdata,
  // Input stream
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [39:0] in_tdata,   // [15:0] pixel_index, [39:16] color
  input  wire logic [1:0]  in_tuser,   // [1:0] func
  // Output stream
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [7:0]       out_tdata,  // [0] line_level, [7:1] zero
  output logic [0:0]       out_tuser,  // [0] busy_res
  output logic             out_tlast   // frame_done
);

  localparam int AW = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;
  localparam int CW = $clog2(LED_COUNT + 1);

  // Index modulo LED_COUNT by reciprocal multiply; exact for 16-bit indexes.
  localparam int           MOD_L = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 0;
  localparam int           MOD_S = arls_pkg::INDEX_W + MOD_L;
  localparam longint       MOD_M_FULL = ((64'd1 << MOD_S) + LED_COUNT - 1) / LED_COUNT;
  localparam logic [17:0]  MOD_M = 18'(MOD_M_FULL);

  // Configuration registers
  logic [7:0] zero_high_r, zero_low_r, one_high_r, one_low_r;

  // Input stage
  logic                         s1_v_r;
  arls_pkg::func_t              s1_func_r;
  logic [arls_pkg::INDEX_W-1:0] s1_idx_r;
  logic [arls_pkg::INDEX_W-1:0] s1_q_r;
  arls_pkg::color_t             s1_color_r;
  logic [33:0]                  in_prod;
  logic [arls_pkg::INDEX_W-1:0] in_q;

  // Serializer state
  logic             sending_r, sending_nxt;
  logic             phase_low_r, phase_low_nxt;
  logic [7:0]       phase_ticks_r, phase_ticks_nxt;
  logic [4:0]       bit_count_r, bit_count_nxt;
  logic [CW-1:0]    pixel_count_r, pixel_count_nxt;
  arls_pkg::color_t shift_word_r, shift_word_nxt;
  logic             pend_r, pend_nxt;

  // Pixel store: RAM plus fill color and written flags
  arls_pkg::color_t fill_color_r;
  logic             written_r [LED_COUNT];
  arls_pkg::color_t ram_rdata;
  logic             ram_we, ram_re;
  logic [AW-1:0]    ram_waddr, ram_raddr;

  // Output register
  logic out_v_r, out_level_r, out_busy_r, out_done_r;

  logic                         proceed;
  logic                         out_free;
  logic [31:0]                  qn;
  logic [arls_pkg::INDEX_W-1:0] idx_rem;
  arls_pkg::color_t             eff_shift;
  logic                         cur_bit;
  logic [7:0]                   limit;
  logic [7:0]                   ticks_inc;
  logic [4:0]                   bits_inc;
  logic [CW-1:0]                pixels_inc;
  logic                         load;
  logic                         done_c;
  logic                         res_level, res_busy;

  assign out_free  = !out_v_r || out_tready;
  assign proceed   = s1_v_r && out_free;
  assign in_tready = !s1_v_r || out_free;

  assign in_prod = 34'(in_tdata[15:0]) * 34'(MOD_M);
  assign in_q    = arls_pkg::INDEX_W'(in_prod >> MOD_S);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      zero_high_r <= arls_pkg::ZERO_HIGH_RST;
      zero_low_r  <= arls_pkg::ZERO_LOW_RST;
      one_high_r  <= arls_pkg::ONE_HIGH_RST;
      one_low_r   <= arls_pkg::ONE_LOW_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        arls_pkg::CFG_ZERO_HIGH: zero_high_r <= cfg_wdata;
        arls_pkg::CFG_ZERO_LOW:  zero_low_r  <= cfg_wdata;
        arls_pkg::CFG_ONE_HIGH:  one_high_r  <= cfg_wdata;
        arls_pkg::CFG_ONE_LOW:   one_low_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_tready) begin
      s1_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_func_r  <= arls_pkg::func_t'(in_tuser);
      s1_idx_r   <= in_tdata[15:0];
      s1_q_r     <= in_q;
      s1_color_r <= in_tdata[39:16];
    end
  end

  // Remainder of the index after the registered quotient.
  assign qn      = 32'(s1_q_r) * 32'(LED_COUNT);
  assign idx_rem = s1_idx_r - qn[arls_pkg::INDEX_W-1:0];

  // A pixel fetched in the previous cycle becomes the shift word now.
  always_comb begin
    if (pend_r) begin
      if (written_r[pixel_count_r[AW-1:0]]) begin
        eff_shift = arls_pkg::grb_word(ram_rdata);
      end else begin
        eff_shift = arls_pkg::grb_word(fill_color_r);
      end
    end else begin
      eff_shift = shift_word_r;
    end
  end

  assign cur_bit    = eff_shift[arls_pkg::COLOR_W-1];
  assign ticks_inc  = phase_ticks_r + 8'd1;
  assign bits_inc   = bit_count_r + 5'd1;
  assign pixels_inc = pixel_count_r + CW'(1);

  always_comb begin
    if (cur_bit) begin
      limit = phase_low_r ? one_low_r : one_high_r;
    end else begin
      limit = phase_low_r ? zero_low_r : zero_high_r;
    end
  end

  always_comb begin
    sending_nxt     = sending_r;
    phase_low_nxt   = phase_low_r;
    phase_ticks_nxt = phase_ticks_r;
    bit_count_nxt   = bit_count_r;
    pixel_count_nxt = pixel_count_r;
    shift_word_nxt  = eff_shift;
    load            = 1'b0;
    done_c          = 1'b0;
    ram_we          = 1'b0;
    ram_raddr       = '0;
    if (proceed) begin
      case (s1_func_r)
        arls_pkg::FUNC_SET_ONE: begin
          ram_we = 1'b1;
        end
        arls_pkg::FUNC_SET_ALL: begin
        end
        arls_pkg::FUNC_START: begin
          if (!sending_r) begin
            sending_nxt     = 1'b1;
            phase_low_nxt   = 1'b0;
            phase_ticks_nxt = 8'd0;
            bit_count_nxt   = 5'd0;
            pixel_count_nxt = '0;
            load            = 1'b1;
          end
        end
        arls_pkg::FUNC_TICK: begin
          if (sending_r) begin
            phase_ticks_nxt = ticks_inc;
            if (ticks_inc >= limit) begin
              phase_ticks_nxt = 8'd0;
              if (!phase_low_r) begin
                phase_low_nxt = 1'b1;
              end else begin
                phase_low_nxt  = 1'b0;
                shift_word_nxt = {eff_shift[arls_pkg::COLOR_W-2:0], 1'b0};
                bit_count_nxt  = bits_inc;
                if (bits_inc >= arls_pkg::BITS_PER_PIXEL) begin
                  if (pixels_inc == CW'(LED_COUNT)) begin
                    sending_nxt     = 1'b0;
                    done_c          = 1'b1;
                    pixel_count_nxt = '0;
                    bit_count_nxt   = 5'd0;
                    shift_word_nxt  = '0;
                  end else begin
                    pixel_count_nxt = pixels_inc;
                    bit_count_nxt   = 5'd0;
                    ram_raddr       = pixels_inc[AW-1:0];
                    load            = 1'b1;
                  end
                end
              end
            end
          end
        end
        default: ;
      endcase
    end
    ram_re   = load;
    pend_nxt = load;
  end

  assign ram_waddr = idx_rem[AW-1:0];

  always_comb begin
    if (s1_func_r == arls_pkg::FUNC_TICK && sending_r) begin
      res_level = !phase_low_r;
      res_busy  = 1'b1;
    end else begin
      res_level = sending_nxt && !phase_low_nxt;
      res_busy  = sending_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sending_r     <= 1'b0;
      phase_low_r   <= 1'b0;
      phase_ticks_r <= 8'd0;
      bit_count_r   <= 5'd0;
      pixel_count_r <= '0;
      shift_word_r  <= '0;
      pend_r        <= 1'b0;
    end else begin
      sending_r     <= sending_nxt;
      phase_low_r   <= phase_low_nxt;
      phase_ticks_r <= phase_ticks_nxt;
      bit_count_r   <= bit_count_nxt;
      pixel_count_r <= pixel_count_nxt;
      shift_word_r  <= shift_word_nxt;
      pend_r        <= pend_nxt;
    end
  end

  // Set all replaces the fill color and forgets every single-pixel write.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_color_r <= '0;
      for (int i = 0; i < LED_COUNT; i++) begin
        written_r[i] <= 1'b0;
      end
    end else if (proceed && s1_func_r == arls_pkg::FUNC_SET_ALL) begin
      fill_color_r <= s1_color_r;
      for (int i = 0; i < LED_COUNT; i++) begin
        written_r[i] <= 1'b0;
      end
    end else if (ram_we) begin
      written_r[ram_waddr] <= 1'b1;
    end
  end

  arls_ram #(
    .WIDTH (arls_pkg::COLOR_W),
    .DEPTH (LED_COUNT)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (s1_color_r),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (out_free) begin
      out_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (proceed) begin
      out_level_r <= res_level;
      out_busy_r  <= res_busy;
      out_done_r  <= done_c;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {7'd0, out_level_r};
  assign out_tuser  = out_busy_r;
  assign out_tlast  = out_done_r;

`ifndef NO_ASSERTIONS
  // A fetched pixel is only pending while a frame is running.
  a_pend_sending: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |-> sending_r)
    else $error("pixel fetch pending while idle");

  // The end-of-frame transaction still reports busy.
  a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tlast) |-> out_tuser[0])
    else $error("frame_done without busy");

  // Ending a frame stops the serializer on the next cycle.
  a_done_stops: assert property (@(posedge clk) disable iff (!rst_n)
    (proceed && done_c) |=> !sending_r)
    else $error("serializer still sending after frame end");

  // A store write and a pixel fetch never come from the same transaction.
  a_rw_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(ram_we && ram_re))
    else $error("store write and fetch in the same cycle");
`endif

endmodule

`default_nettype wire
